>>> rtl/kvlp_pkg.sv
// shared constants, types and character helpers of the key/value line parser
// no dependencies; used by key_value_line_parser_top
package kvlp_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_kind;

    localparam int MAX_SPACE_RUN = 62;
    localparam int RUN_DEPTH     = 62;
    localparam int RUN_AW        = 6;

    localparam t_byte C_NEWLINE = 8'h0A;
    localparam t_byte C_EQUALS  = 8'h3D;
    localparam t_byte C_PERCENT = 8'h25;

    localparam t_kind KIND_DATA  = 2'd0;
    localparam t_kind KIND_OK    = 2'd1;
    localparam t_kind KIND_NO_EQ = 2'd2;
    localparam t_kind KIND_OVF   = 2'd3;

    function automatic logic is_ws(input t_byte c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input t_byte c);
        t_byte d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // rebuilds the held hex digit as it arrived
    function automatic t_byte digit_char(input logic [3:0] d, input logic lower);
        if (d < 4'd10) begin
            return 8'h30 + {4'b0000, d};
        end
        return (lower ? 8'h57 : 8'h37) + {4'b0000, d};
    endfunction

endpackage

>>> rtl/key_value_line_parser_top.sv
// key/value line parser: splits a line at the first '=', trims whitespace and
// percent-decodes the value; held whitespace lives in a ram; depends on kvlp_pkg
// timing: a direct result shows the cycle after its byte is accepted; a released '%' passes
// through S_PCT, a whitespace flush through S_FLRD and S_FLEM; one result leaves per cycle
// while i_stall does not hold it, and new bytes are stalled until a release is done;
// reset: synchronous active low, ram not cleared
module key_value_line_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_value,
    output logic [1:0] o_kind,
    output logic       o_last
);

    localparam logic [1:0] PH_NAME_LEAD = 2'd0;
    localparam logic [1:0] PH_NAME_BODY = 2'd1;
    localparam logic [1:0] PH_VAL_LEAD  = 2'd2;
    localparam logic [1:0] PH_VAL_BODY  = 2'd3;

    localparam logic [1:0] PCT_NONE  = 2'd0;
    localparam logic [1:0] PCT_ONE   = 2'd1;
    localparam logic [1:0] PCT_DIGIT = 2'd2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PCT  = 3'd1;
    localparam logic [2:0] S_DIG  = 3'd2;
    localparam logic [2:0] S_FLRD = 3'd3;
    localparam logic [2:0] S_FLEM = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [kvlp_pkg::RUN_AW-1:0] RUN_MAX = kvlp_pkg::RUN_AW'(kvlp_pkg::MAX_SPACE_RUN);

    // control state
    logic [2:0]                   r_state, n_state;
    logic [1:0]                   r_phase, n_phase;
    logic [1:0]                   r_pct, n_pct;
    logic [3:0]                   r_fdig, n_fdig;
    logic                         r_flow, n_flow;
    logic                         r_ovf, n_ovf;
    logic [kvlp_pkg::RUN_AW-1:0]  r_space_count;
    logic [kvlp_pkg::RUN_AW-1:0]  r_idx;
    logic                         r_do_dig, r_do_flush, r_do_fin;
    logic                         r_out_valid;

    // payload
    kvlp_pkg::t_byte              r_space_run [kvlp_pkg::RUN_DEPTH];
    kvlp_pkg::t_byte              r_rd_data;
    kvlp_pkg::t_byte              r_fin_byte;
    logic                         r_fin_isv;
    kvlp_pkg::t_kind              r_fin_kind;
    logic                         r_fin_last;
    logic                         r_fl_isv;
    kvlp_pkg::t_byte              r_dig_char;
    kvlp_pkg::t_byte              r_out_byte, n_out_byte;
    logic                         r_out_isv, n_out_isv;
    kvlp_pkg::t_kind              r_out_kind, n_out_kind;
    logic                         r_out_last, n_out_last;

    // decode of the accepted byte
    logic                         acc, out_free, out_ld;
    logic                         dec_pct, dec_dig, dec_flush, dec_fin, dec_push, dec_clear;
    logic                         dec_cont, dec_ws;
    logic [4:0]                   dec_hex;
    kvlp_pkg::t_byte              dec_fin_byte;
    logic                         dec_fin_isv;
    kvlp_pkg::t_kind              dec_fin_kind;
    logic                         dec_fin_last;
    logic                         dec_isv;
    logic                         mem_we, rd_en, fl_done;
    logic [kvlp_pkg::RUN_AW-1:0]  rd_addr;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign acc      = i_valid && !o_stall;

    always_comb begin
        n_phase      = r_phase;
        n_pct        = r_pct;
        n_fdig       = r_fdig;
        n_flow       = r_flow;
        n_ovf        = r_ovf;
        dec_pct      = 1'b0;
        dec_dig      = 1'b0;
        dec_flush    = 1'b0;
        dec_fin      = 1'b0;
        dec_push     = 1'b0;
        dec_clear    = 1'b0;
        dec_cont     = 1'b0;
        dec_isv      = 1'b0;
        dec_fin_byte = i_in_byte;
        dec_fin_isv  = 1'b0;
        dec_fin_kind = kvlp_pkg::KIND_DATA;
        dec_fin_last = 1'b0;
        dec_ws       = kvlp_pkg::is_ws(i_in_byte);
        dec_hex      = kvlp_pkg::hex_val(i_in_byte);

        if (i_in_byte == kvlp_pkg::C_NEWLINE) begin
            // held percent comes out literally, held whitespace is dropped
            dec_pct      = (r_phase == PH_VAL_BODY) && (r_pct != PCT_NONE);
            dec_dig      = (r_phase == PH_VAL_BODY) && (r_pct == PCT_DIGIT);
            dec_fin      = 1'b1;
            dec_fin_byte = 8'h00;
            dec_fin_last = 1'b1;
            dec_clear    = 1'b1;
            if (r_phase == PH_NAME_LEAD || r_phase == PH_NAME_BODY) begin
                dec_fin_kind = kvlp_pkg::KIND_NO_EQ;
            end else if (r_ovf) begin
                dec_fin_kind = kvlp_pkg::KIND_OVF;
            end else begin
                dec_fin_kind = kvlp_pkg::KIND_OK;
            end
            n_phase = PH_NAME_LEAD;
            n_pct   = PCT_NONE;
            n_fdig  = 4'd0;
            n_flow  = 1'b0;
            n_ovf   = 1'b0;
        end else begin
            unique case (r_phase)
                PH_NAME_LEAD: begin
                    if (dec_ws) begin
                    end else if (i_in_byte == kvlp_pkg::C_EQUALS) begin
                        n_phase = PH_VAL_LEAD;
                    end else begin
                        n_phase = PH_NAME_BODY;
                        dec_fin = 1'b1;
                    end
                end
                PH_NAME_BODY: begin
                    if (dec_ws) begin
                        dec_push = 1'b1;
                    end else if (i_in_byte == kvlp_pkg::C_EQUALS) begin
                        dec_clear = 1'b1;
                        n_phase   = PH_VAL_LEAD;
                    end else begin
                        dec_flush = (r_space_count != '0);
                        dec_fin   = 1'b1;
                    end
                end
                PH_VAL_LEAD, PH_VAL_BODY: begin
                    if (!(r_phase == PH_VAL_LEAD && dec_ws)) begin
                        n_phase  = PH_VAL_BODY;
                        dec_cont = 1'b1;
                        if (r_pct == PCT_ONE) begin
                            if (dec_hex[4]) begin
                                n_fdig   = dec_hex[3:0];
                                n_flow   = (i_in_byte >= 8'h61);
                                n_pct    = PCT_DIGIT;
                                dec_cont = 1'b0;
                            end else begin
                                dec_pct = 1'b1;
                                n_pct   = PCT_NONE;
                            end
                        end else if (r_pct == PCT_DIGIT) begin
                            if (dec_hex[4]) begin
                                dec_fin      = 1'b1;
                                dec_fin_byte = {r_fdig, dec_hex[3:0]};
                                dec_fin_isv  = 1'b1;
                                n_pct        = PCT_NONE;
                                dec_cont     = 1'b0;
                            end else begin
                                dec_pct = 1'b1;
                                dec_dig = 1'b1;
                                n_pct   = PCT_NONE;
                            end
                        end
                        if (dec_cont) begin
                            if (dec_ws) begin
                                dec_push = 1'b1;
                            end else begin
                                dec_flush = (r_space_count != '0);
                                dec_isv   = 1'b1;
                                if (i_in_byte == kvlp_pkg::C_PERCENT) begin
                                    n_pct = PCT_ONE;
                                end else begin
                                    dec_fin     = 1'b1;
                                    dec_fin_isv = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            if (dec_push && r_space_count >= RUN_MAX) begin
                n_ovf = 1'b1;
            end
        end
    end

    assign mem_we  = acc && dec_push && (r_space_count < RUN_MAX);
    assign fl_done = (r_idx + 1'b1) == r_space_count;

    // reads run one entry ahead of the emitted byte
    always_comb begin
        rd_addr = '0;
        if (r_state == S_FLEM) begin
            rd_addr = out_free ? r_idx + 1'b1 : r_idx;
        end
        rd_en = ((r_state == S_FLRD) || (r_state == S_FLEM)) && (rd_addr < r_space_count);
    end

    always_comb begin
        n_state    = r_state;
        out_ld     = 1'b0;
        n_out_byte = r_fin_byte;
        n_out_isv  = r_fin_isv;
        n_out_kind = r_fin_kind;
        n_out_last = r_fin_last;
        unique case (r_state)
            S_IDLE: begin
                n_out_byte = dec_fin_byte;
                n_out_isv  = dec_fin_isv;
                n_out_kind = dec_fin_kind;
                n_out_last = dec_fin_last;
                if (acc) begin
                    priority if (dec_pct) begin
                        n_state = S_PCT;
                    end else if (dec_flush) begin
                        n_state = S_FLRD;
                    end else begin
                        out_ld = dec_fin;
                    end
                end
            end
            S_PCT: begin
                n_out_byte = kvlp_pkg::C_PERCENT;
                n_out_isv  = 1'b1;
                n_out_kind = kvlp_pkg::KIND_DATA;
                n_out_last = 1'b0;
                if (out_free) begin
                    out_ld = 1'b1;
                    priority if (r_do_dig) begin
                        n_state = S_DIG;
                    end else if (r_do_flush) begin
                        n_state = S_FLRD;
                    end else if (r_do_fin) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIG: begin
                n_out_byte = r_dig_char;
                n_out_isv  = 1'b1;
                n_out_kind = kvlp_pkg::KIND_DATA;
                n_out_last = 1'b0;
                if (out_free) begin
                    out_ld = 1'b1;
                    priority if (r_do_flush) begin
                        n_state = S_FLRD;
                    end else if (r_do_fin) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FLRD: begin
                n_state = S_FLEM;
            end
            S_FLEM: begin
                n_out_byte = r_rd_data;
                n_out_isv  = r_fl_isv;
                n_out_kind = kvlp_pkg::KIND_DATA;
                n_out_last = 1'b0;
                if (out_free) begin
                    out_ld = 1'b1;
                    if (fl_done) begin
                        n_state = r_do_fin ? S_FIN : S_IDLE;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    out_ld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_NAME_LEAD;
            r_pct         <= PCT_NONE;
            r_fdig        <= 4'd0;
            r_flow        <= 1'b0;
            r_ovf         <= 1'b0;
            r_space_count <= '0;
            r_idx         <= '0;
            r_do_dig      <= 1'b0;
            r_do_flush    <= 1'b0;
            r_do_fin      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_free) begin
                r_out_valid <= out_ld;
            end
            if (acc) begin
                r_phase    <= n_phase;
                r_pct      <= n_pct;
                r_fdig     <= n_fdig;
                r_flow     <= n_flow;
                r_ovf      <= n_ovf;
                r_do_dig   <= dec_dig;
                r_do_flush <= dec_flush;
                r_do_fin   <= dec_fin;
                r_idx      <= '0;
                if (dec_clear) begin
                    r_space_count <= '0;
                end else if (mem_we) begin
                    r_space_count <= r_space_count + 1'b1;
                end
            end
            if (r_state == S_FLEM && out_free) begin
                if (fl_done) begin
                    r_space_count <= '0;
                    r_idx         <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_fin_byte <= dec_fin_byte;
            r_fin_isv  <= dec_fin_isv;
            r_fin_kind <= dec_fin_kind;
            r_fin_last <= dec_fin_last;
            r_fl_isv   <= dec_isv;
            r_dig_char <= kvlp_pkg::digit_char(r_fdig, r_flow);
        end
        if (out_free && out_ld) begin
            r_out_byte <= n_out_byte;
            r_out_isv  <= n_out_isv;
            r_out_kind <= n_out_kind;
            r_out_last <= n_out_last;
        end
    end

    // whitespace run ram, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_space_run[r_space_count] <= i_in_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_space_run[rd_addr];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_is_value = r_out_isv;
    assign o_kind     = r_out_kind;
    assign o_last     = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_space_count <= RUN_MAX)
        else $error("whitespace run count beyond its limit");

    a_pct_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pct != PCT_NONE && r_state == S_IDLE) |-> r_space_count == '0)
        else $error("percent held while whitespace is still held");

    a_pct_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pct != PCT_NONE) |-> r_phase == PH_VAL_BODY)
        else $error("percent held outside the value body");

    a_flush_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLEM) |-> r_idx < r_space_count)
        else $error("flush index past the held run");

    a_flush_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLRD) |=> r_state == S_FLEM)
        else $error("flush read not followed by emission");

endmodule

>>> dv/tb_top.sv
// self-checking testbench for key_value_line_parser_top: line bytes in, parsed bytes and
// an end-of-line status out, predicted on the fly and compared in order
// depends on kvlp_pkg and key_value_line_parser_top
module tb_top;

    localparam int TIMEOUT       = 2_000_000;
    localparam int TOTAL_ITEMS   = 180;
    localparam int DRAIN_CYCLES  = 100;
    localparam int CALM_FROM     = 100;
    localparam int CALM_TO       = 250;

    typedef enum logic [1:0] {LN_NAME_LEAD, LN_NAME, LN_VALUE_LEAD, LN_VALUE} t_line_phase;
    typedef enum logic [1:0] {PCT_IDLE, PCT_SIGN, PCT_NIBBLE} t_pct_state;

    typedef struct packed {
        logic [7:0] data;
        logic       is_value;
        logic [1:0] kind;
        logic       last;
    } t_parsed_item;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_is_value;
    logic [1:0] o_kind;
    logic       o_last;

    logic [7:0]   line_bytes_q[$];
    t_parsed_item parsed_q[$];
    int           fail_count = 0;
    int           cyc        = 0;

    // parser state as predicted
    t_line_phase  ln_phase  = LN_NAME_LEAD;
    t_pct_state   pct       = PCT_IDLE;
    logic [7:0]   held_char = 8'h00;
    logic [7:0]   blank_run[$];
    logic         run_lost  = 1'b0;

    key_value_line_parser_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_is_value (o_is_value),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    function automatic logic idle_now();
        if (cyc >= CALM_FROM && cyc < CALM_TO) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 10;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] nib);
        nib = 4'h0;
        if (c inside {[8'h30:8'h39]}) begin
            nib = c[3:0];
            return 1'b1;
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            nib = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ---------------- prediction ----------------

    task automatic add_parsed(input logic [7:0] b, input logic isv, input logic [1:0] k,
                              input logic lst);
        t_parsed_item r;
        r = '{b, isv, k, lst};
        parsed_q.push_back(r);
    endtask

    task automatic hold_blank(input logic [7:0] c);
        if (blank_run.size() < kvlp_pkg::MAX_SPACE_RUN) begin
            blank_run.push_back(c);
        end else begin
            run_lost = 1'b1;
        end
    endtask

    task automatic release_blanks(input logic isv);
        foreach (blank_run[i]) begin
            add_parsed(blank_run[i], isv, kvlp_pkg::KIND_DATA, 1'b0);
        end
        blank_run.delete();
    endtask

    task automatic value_char(input logic [7:0] c);
        logic [3:0] lo;
        logic [3:0] hi;
        logic       is_hex;
        is_hex = hex_nibble(c, lo);
        if (pct == PCT_SIGN) begin
            if (is_hex) begin
                held_char = c;
                pct = PCT_NIBBLE;
                return;
            end
            add_parsed(kvlp_pkg::C_PERCENT, 1'b1, kvlp_pkg::KIND_DATA, 1'b0);
            pct = PCT_IDLE;
        end else if (pct == PCT_NIBBLE) begin
            if (is_hex) begin
                void'(hex_nibble(held_char, hi));
                add_parsed({hi, lo}, 1'b1, kvlp_pkg::KIND_DATA, 1'b0);
                pct = PCT_IDLE;
                return;
            end
            // digit did not pair up: both go out as typed
            add_parsed(kvlp_pkg::C_PERCENT, 1'b1, kvlp_pkg::KIND_DATA, 1'b0);
            add_parsed(held_char, 1'b1, kvlp_pkg::KIND_DATA, 1'b0);
            pct = PCT_IDLE;
        end
        if (is_blank(c)) begin
            hold_blank(c);
            return;
        end
        release_blanks(1'b1);
        if (c == kvlp_pkg::C_PERCENT) begin
            pct = PCT_SIGN;
        end else begin
            add_parsed(c, 1'b1, kvlp_pkg::KIND_DATA, 1'b0);
        end
    endtask

    task automatic parse_byte(input logic [7:0] c);
        logic [1:0] status;
        if (c == kvlp_pkg::C_NEWLINE) begin
            if (ln_phase == LN_VALUE && pct != PCT_IDLE) begin
                add_parsed(kvlp_pkg::C_PERCENT, 1'b1, kvlp_pkg::KIND_DATA, 1'b0);
                if (pct == PCT_NIBBLE) begin
                    add_parsed(held_char, 1'b1, kvlp_pkg::KIND_DATA, 1'b0);
                end
            end
            if (ln_phase == LN_NAME_LEAD || ln_phase == LN_NAME) begin
                status = kvlp_pkg::KIND_NO_EQ;
            end else if (run_lost) begin
                status = kvlp_pkg::KIND_OVF;
            end else begin
                status = kvlp_pkg::KIND_OK;
            end
            add_parsed(8'h00, 1'b0, status, 1'b1);
            ln_phase = LN_NAME_LEAD;
            pct = PCT_IDLE;
            held_char = 8'h00;
            blank_run.delete();
            run_lost = 1'b0;
            return;
        end
        case (ln_phase)
            LN_NAME_LEAD: begin
                if (c == kvlp_pkg::C_EQUALS) begin
                    ln_phase = LN_VALUE_LEAD;
                end else if (!is_blank(c)) begin
                    ln_phase = LN_NAME;
                    add_parsed(c, 1'b0, kvlp_pkg::KIND_DATA, 1'b0);
                end
            end
            LN_NAME: begin
                if (is_blank(c)) begin
                    hold_blank(c);
                end else if (c == kvlp_pkg::C_EQUALS) begin
                    // trailing blanks of the name are dropped
                    blank_run.delete();
                    ln_phase = LN_VALUE_LEAD;
                end else begin
                    release_blanks(1'b0);
                    add_parsed(c, 1'b0, kvlp_pkg::KIND_DATA, 1'b0);
                end
            end
            LN_VALUE_LEAD: begin
                if (!is_blank(c)) begin
                    ln_phase = LN_VALUE;
                    value_char(c);
                end
            end
            default: begin
                value_char(c);
            end
        endcase
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_byte(i_in_byte);
            end
            if (!i_valid || !o_stall) begin
                if (line_bytes_q.size() != 0 && !idle_now()) begin
                    i_valid   <= 1'b1;
                    i_in_byte <= line_bytes_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    task automatic log_failure(input string what, input t_parsed_item want,
                               input t_parsed_item got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t %s: expected byte %02h value %0b kind %0d last %0b", $realtime,
                     what, want.data, want.is_value, want.kind, want.last);
            $display("    got byte %02h value %0b kind %0d last %0b",
                     got.data, got.is_value, got.kind, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_parsed_item got;
        t_parsed_item want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_out_byte, o_is_value, o_kind, o_last};
                if (parsed_q.size() == 0) begin
                    log_failure("transaction with nothing expected", '0, got);
                end else begin
                    want = parsed_q.pop_front();
                    if (got !== want) begin
                        log_failure("mismatch", want, got);
                    end
                end
            end
            i_stall <= idle_now();
        end
    end

    // ---------------- stimulus ----------------

    task automatic push_byte(input logic [7:0] b);
        line_bytes_q.push_back(b);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_bytes_q.push_back(s[i]);
        end
    endtask

    function automatic logic [7:0] rand_blank();
        logic [7:0] pick[5];
        pick = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
        return pick[$urandom_range(0, 4)];
    endfunction

    task automatic push_blanks(input int n);
        repeat (n) push_byte(rand_blank());
    endtask

    // mostly short runs, now and then one around the hold limit
    function automatic int run_len();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(kvlp_pkg::MAX_SPACE_RUN - 2, kvlp_pkg::MAX_SPACE_RUN + 4);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (is_blank(c) || c == kvlp_pkg::C_NEWLINE || c == kvlp_pkg::C_EQUALS
                   || c == kvlp_pkg::C_PERCENT);
        return c;
    endfunction

    function automatic logic [7:0] rand_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] rand_nonhex();
        logic [7:0] c;
        logic [3:0] nib;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (c == kvlp_pkg::C_NEWLINE || hex_nibble(c, nib));
        return c;
    endfunction

    task automatic gen_part(input logic in_value);
        int pieces;
        pieces = $urandom_range(0, 5);
        repeat (pieces) begin
            case ($urandom_range(0, 8))
                4: push_blanks(run_len());
                5: begin
                    push_byte(kvlp_pkg::C_PERCENT);
                    push_byte(rand_hex());
                    push_byte(rand_hex());
                end
                6: begin
                    push_byte(kvlp_pkg::C_PERCENT);
                    push_byte(rand_hex());
                    push_byte(rand_nonhex());
                end
                7: begin
                    push_byte(kvlp_pkg::C_PERCENT);
                    push_byte(rand_nonhex());
                end
                8: push_byte(in_value ? kvlp_pkg::C_EQUALS : rand_plain());
                default: push_byte(rand_plain());
            endcase
        end
        // may end on a bare '%' or '%' plus one digit
        case ($urandom_range(0, 5))
            0: push_byte(kvlp_pkg::C_PERCENT);
            1: begin
                push_byte(kvlp_pkg::C_PERCENT);
                push_byte(rand_hex());
            end
            2, 3: push_blanks(run_len());
            default: ;
        endcase
    endtask

    task automatic gen_line();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            // noise, may contain its own line ends
            repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(1, 255)));
            push_byte(kvlp_pkg::C_NEWLINE);
            return;
        end
        push_blanks($urandom_range(0, 2));
        gen_part(1'b0);
        if (sel != 1) begin
            push_byte(kvlp_pkg::C_EQUALS);
            push_blanks($urandom_range(0, 2));
            gen_part(1'b1);
        end
        push_byte(kvlp_pkg::C_NEWLINE);
    endtask

    initial begin
        // empty line, empty name and value
        push_byte(kvlp_pkg::C_NEWLINE);
        push_str("=");
        push_byte(kvlp_pkg::C_NEWLINE);
        // blank trimming, '%' in name, decoding, broken escapes, '=' in value
        push_byte(8'h20);
        push_str("a%b");
        push_byte(8'h09);
        push_byte(8'h20);
        push_str("=");
        push_byte(8'h0B);
        push_str("1%2f%Bb=%4g%z");
        push_byte(8'h0D);
        push_byte(kvlp_pkg::C_NEWLINE);
        // byte extremes, escape cut short by the line end
        push_byte(8'hFF);
        push_byte(8'h01);
        push_str("=%a");
        push_byte(kvlp_pkg::C_NEWLINE);
        push_str("x=%");
        push_byte(kvlp_pkg::C_NEWLINE);
        // a run one past the hold limit: only the held part of the run is released and the line overflows
        push_str("n");
        push_blanks(kvlp_pkg::MAX_SPACE_RUN + 1);
        push_str("y=v");
        push_blanks(3);
        push_str("w");
        push_blanks(3);
        push_byte(kvlp_pkg::C_NEWLINE);

        while (line_bytes_q.size() < TOTAL_ITEMS) begin
            gen_line();
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (line_bytes_q.size() != 0 || i_valid || parsed_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && parsed_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #TIMEOUT;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
